### design/sorted_key_index_table_top_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros for the sorted key index table
// Shared property wrappers for the checks in the table modules.
// ---------------------------------------------------------------------------
`ifndef SORTED_KEY_INDEX_TABLE_TOP_MACROS_SVH
`define SORTED_KEY_INDEX_TABLE_TOP_MACROS_SVH

// implication checked every clock outside reset
`define SKIT_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication checked every clock outside reset
`define SKIT_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### design/skit_pkg.sv
// ---------------------------------------------------------------------------
// Sorted key index table package
// Sizes, codes, state encoding and the compare function.
// ---------------------------------------------------------------------------
package skit_pkg;

  localparam int TABLE_DEPTH = 128;
  localparam int ADDR_BITS   = 16;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
  localparam int KEY_W       = 112;
  localparam int HALF_W      = 56;
  localparam int ENTRY_W     = KEY_W + ADDR_BITS;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_LOOKUP = 2'd1,
    OP_DELETE = 2'd2,
    OP_READ   = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_NOTFOUND = 3'd1,
    ST_DUP      = 3'd2,
    ST_FULL     = 3'd3,
    ST_RANGE    = 3'd4
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SRCH,
    S_SWAIT,
    S_SCMP,
    S_DECIDE,
    S_INS_RD,
    S_INS_WR,
    S_DEL_RD,
    S_DEL_WR,
    S_RD_WAIT,
    S_RD_DONE,
    S_OUT
  } state_t;

  // compare result of the shared comparator
  typedef struct packed {
    logic eq;
    logic gt;
  } cmp_t;

  function automatic cmp_t key_compare(input logic [KEY_W-1:0] a,
                                       input logic [KEY_W-1:0] b);
    cmp_t c;
    c.eq = (a == b);
    c.gt = (a > b);
    return c;
  endfunction

endpackage

### design/skit_ram.sv
// ---------------------------------------------------------------------------
// Generic single-port RAM
// One write or one read per cycle, registered read data.
// ---------------------------------------------------------------------------
module skit_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata_r <= mem[addr];
  end

  assign rdata = rdata_r;

endmodule

### design/skit_seq.sv
// ---------------------------------------------------------------------------
// Sorted key index table sequencer
// Binary search with one shared comparator, then entry shift by sweep.
// ---------------------------------------------------------------------------
`include "sorted_key_index_table_top_macros.svh"

module skit_seq (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  input  skit_pkg::op_t                  op,
  input  logic [skit_pkg::KEY_W-1:0]     key,
  input  logic [skit_pkg::ADDR_BITS-1:0] addr_in,
  input  logic [6:0]                     rd_pos,
  input  logic                           res_taken,
  output logic                           busy,
  output logic                           res_valid,
  output skit_pkg::status_t              res_status,
  output logic [skit_pkg::IDX_W-1:0]     res_pos,
  output logic [skit_pkg::ADDR_BITS-1:0] res_addr,
  output logic [skit_pkg::KEY_W-1:0]     res_key,
  output logic [skit_pkg::CNT_W-1:0]     res_count,
  output logic                           ram_we,
  output logic [skit_pkg::IDX_W-1:0]     ram_addr,
  output logic [skit_pkg::ENTRY_W-1:0]   ram_wdata,
  input  logic [skit_pkg::ENTRY_W-1:0]   ram_rdata
);
  import skit_pkg::*;

  state_t               state_r, state_nxt;
  logic [CNT_W-1:0]     count_r, count_nxt;
  logic [CNT_W-1:0]     lo_r, lo_nxt, hi_r, hi_nxt;
  logic [CNT_W-1:0]     j_r, j_nxt;
  logic                 hit_r, hit_nxt;
  logic [ADDR_BITS-1:0] faddr_r, faddr_nxt;
  logic [KEY_W-1:0]     fkey_r, fkey_nxt;
  status_t              st_r, st_nxt;
  logic [CNT_W-1:0]     pos_r, pos_nxt;
  op_t                  op_r;
  logic [KEY_W-1:0]     key_r;
  logic [ADDR_BITS-1:0] addr_r;
  logic [6:0]           rdp_r;
  logic [CNT_W-1:0]     mid;
  cmp_t                 cmp;

  assign mid = lo_r + ((hi_r - lo_r) >> 1);
  assign cmp = key_compare(key_r, ram_rdata[ENTRY_W-1:ADDR_BITS]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
    end
    lo_r <= lo_nxt;
    hi_r <= hi_nxt;
    j_r <= j_nxt;
    hit_r <= hit_nxt;
    faddr_r <= faddr_nxt;
    fkey_r <= fkey_nxt;
    st_r <= st_nxt;
    pos_r <= pos_nxt;
    if (start) begin
      op_r <= op;
      key_r <= key;
      addr_r <= addr_in;
      rdp_r <= rd_pos;
    end
  end

  always_comb begin
    state_nxt = state_r;
    count_nxt = count_r;
    lo_nxt = lo_r;
    hi_nxt = hi_r;
    j_nxt = j_r;
    hit_nxt = hit_r;
    faddr_nxt = faddr_r;
    fkey_nxt = fkey_r;
    st_nxt = st_r;
    pos_nxt = pos_r;
    ram_we = 1'b0;
    ram_addr = mid[IDX_W-1:0];
    ram_wdata = ram_rdata;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          lo_nxt = '0;
          hi_nxt = count_r;
          hit_nxt = 1'b0;
          faddr_nxt = '0;
          fkey_nxt = '0;
          st_nxt = ST_OK;
          pos_nxt = '0;
          state_nxt = (op == OP_READ) ? S_RD_WAIT : S_SRCH;
        end
      end
      S_SRCH: begin
        if (lo_r < hi_r) begin
          state_nxt = S_SWAIT;
        end else begin
          state_nxt = S_DECIDE;
        end
      end
      S_SWAIT: state_nxt = S_SCMP;
      S_SCMP: begin
        if (cmp.eq) begin
          hit_nxt = 1'b1;
          lo_nxt = mid;
          faddr_nxt = ram_rdata[ADDR_BITS-1:0];
          state_nxt = S_DECIDE;
        end else begin
          if (cmp.gt) lo_nxt = mid + 1'b1;
          else hi_nxt = mid;
          state_nxt = S_SRCH;
        end
      end
      S_DECIDE: begin
        pos_nxt = lo_r;
        j_nxt = count_r;
        case (op_r)
          OP_INSERT: begin
            if (hit_r) begin
              st_nxt = ST_DUP;
              state_nxt = S_OUT;
            end else if (count_r >= CNT_W'(TABLE_DEPTH)) begin
              st_nxt = ST_FULL;
              pos_nxt = '0;
              state_nxt = S_OUT;
            end else begin
              state_nxt = S_INS_RD;
            end
          end
          OP_DELETE: begin
            if (hit_r) begin
              j_nxt = lo_r;
              state_nxt = S_DEL_RD;
            end else begin
              st_nxt = ST_NOTFOUND;
              pos_nxt = '0;
              state_nxt = S_OUT;
            end
          end
          default: begin
            if (!hit_r) begin
              st_nxt = ST_NOTFOUND;
              pos_nxt = '0;
            end
            state_nxt = S_OUT;
          end
        endcase
      end
      S_INS_RD: begin
        // move entry j-1 up to j, down to the insertion point
        if (j_r > lo_r) begin
          ram_addr = IDX_W'(j_r - 1'b1);
          state_nxt = S_INS_WR;
        end else begin
          ram_we = 1'b1;
          ram_addr = lo_r[IDX_W-1:0];
          ram_wdata = {key_r, addr_r};
          count_nxt = count_r + 1'b1;
          state_nxt = S_OUT;
        end
      end
      S_INS_WR: begin
        ram_we = 1'b1;
        ram_addr = j_r[IDX_W-1:0];
        j_nxt = j_r - 1'b1;
        state_nxt = S_INS_RD;
      end
      S_DEL_RD: begin
        if (j_r + 1'b1 < count_r) begin
          ram_addr = IDX_W'(j_r + 1'b1);
          state_nxt = S_DEL_WR;
        end else begin
          count_nxt = count_r - 1'b1;
          state_nxt = S_OUT;
        end
      end
      S_DEL_WR: begin
        ram_we = 1'b1;
        ram_addr = j_r[IDX_W-1:0];
        j_nxt = j_r + 1'b1;
        state_nxt = S_DEL_RD;
      end
      S_RD_WAIT: begin
        ram_addr = rdp_r[IDX_W-1:0];
        if (CNT_W'(rdp_r) >= count_r) begin
          st_nxt = ST_RANGE;
          state_nxt = S_OUT;
        end else begin
          pos_nxt = CNT_W'(rdp_r);
          state_nxt = S_RD_DONE;
        end
      end
      S_RD_DONE: begin
        faddr_nxt = ram_rdata[ADDR_BITS-1:0];
        fkey_nxt = ram_rdata[ENTRY_W-1:ADDR_BITS];
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (res_taken) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign busy = (state_r != S_IDLE);
  assign res_valid = (state_r == S_OUT);
  assign res_status = st_r;
  assign res_pos = pos_r[IDX_W-1:0];
  assign res_addr = faddr_r;
  assign res_key = fkey_r;
  assign res_count = count_r;

  `SKIT_ASSERT_IMP(a_count_range, 1'b1, count_r <= CNT_W'(TABLE_DEPTH), "count past depth")
  `SKIT_ASSERT_IMP(a_lo_hi, state_r == S_SRCH, lo_r <= hi_r, "search bounds crossed")
  `SKIT_ASSERT_NXT(a_res_hold, res_valid && !res_taken, res_valid && $stable(st_r),
                   "result dropped")
  `SKIT_ASSERT_IMP(a_no_wr_idle, state_r == S_IDLE, !ram_we, "store written while idle")

endmodule

### design/sorted_key_index_table_top.sv
// Flow, acceptance to out_valid: search passes S_SRCH, S_SWAIT and S_SCMP per halving step, then
// S_DECIDE; read passes S_RD_WAIT and S_RD_DONE, or S_RD_WAIT alone when the position is out of range.
// Insert and delete add a read state and a write state per shifted entry, plus a closing state.
// Throughput: one transfer at a time; in_ready stays low until the result transfer.
// Reset: synchronous active-low rst_n clears the entry count and sequencer;
// the RAM contents are left as they are and only counted entries are read.
// ---------------------------------------------------------------------------
// Sorted key index table top level
// Keeps key/address pairs in ascending order in one RAM.
// ---------------------------------------------------------------------------
module sorted_key_index_table_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_opcode,
  input  logic [55:0] in_key_high,
  input  logic [55:0] in_key_low,
  input  logic [15:0] in_record_addr,
  input  logic [6:0]  in_read_position,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  out_status,
  output logic [6:0]  out_position,
  output logic [15:0] out_found_addr,
  output logic [55:0] out_found_key_high,
  output logic [55:0] out_found_key_low,
  output logic [7:0]  out_entry_count
);
  import skit_pkg::*;

  logic                 busy, res_valid, ram_we;
  logic [IDX_W-1:0]     ram_addr, res_pos;
  logic [ENTRY_W-1:0]   ram_wdata, ram_rdata;
  status_t              res_status;
  logic [ADDR_BITS-1:0] res_addr;
  logic [KEY_W-1:0]     res_key;
  logic [CNT_W-1:0]     res_count;

  // new transfer only while the sequencer is parked
  assign in_ready = !busy;

  skit_seq u_seq (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (in_valid && in_ready),
    .op         (op_t'(in_opcode)),
    .key        ({in_key_high, in_key_low}),
    .addr_in    (in_record_addr),
    .rd_pos     (in_read_position),
    .res_taken  (out_ready),
    .busy       (busy),
    .res_valid  (res_valid),
    .res_status (res_status),
    .res_pos    (res_pos),
    .res_addr   (res_addr),
    .res_key    (res_key),
    .res_count  (res_count),
    .ram_we     (ram_we),
    .ram_addr   (ram_addr),
    .ram_wdata  (ram_wdata),
    .ram_rdata  (ram_rdata)
  );

  // key in the upper bits, record address in the lower
  skit_ram #(.WIDTH(ENTRY_W), .DEPTH(TABLE_DEPTH)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  assign out_valid          = res_valid;
  assign out_status         = res_status;
  assign out_position       = 7'(res_pos);
  assign out_found_addr     = 16'(res_addr);
  assign out_found_key_high = res_key[KEY_W-1:HALF_W];
  assign out_found_key_low  = res_key[HALF_W-1:0];
  assign out_entry_count    = 8'(res_count);

endmodule
